FILE: design/rn_pkg.sv
package rn_pkg;

    // Thirteen greedy terms, from 1000 down to 1.
    localparam int unsigned NTERMS = 13;
    localparam int unsigned TERM_W = 4;
    localparam int unsigned VALUE_W = 12;
    localparam int unsigned CHAR_W = 7;

    // Largest value that has a numeral.
    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // ASCII codes of the numeral symbols.
    localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
    localparam logic [CHAR_W-1:0] CH_I    = 7'h49;
    localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
    localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
    localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
    localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
    localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take a convertible value and start at the first term
        logic special;  // load the single zero or out-of-range result
        logic emit;     // move the current symbol into the output register
        logic skip;     // current term no longer fits, go to the next one
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero;     // incoming value is zero
        logic over;     // incoming value exceeds the largest numeral
        logic hit;      // current term still fits into the remainder
        logic last;     // symbol on offer closes the numeral
    } t_stat;

    // Weight of each term.
    function automatic logic [VALUE_W-1:0] term_weight(input logic [TERM_W-1:0] t);
        logic [VALUE_W-1:0] w;
        unique case (t)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // First symbol of each term.
    function automatic logic [CHAR_W-1:0] term_first(input logic [TERM_W-1:0] t);
        logic [CHAR_W-1:0] c;
        unique case (t)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            4'd11:   c = CH_I;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    // Second symbol of a subtractive pair; none for a single-symbol term.
    function automatic logic [CHAR_W-1:0] term_second(input logic [TERM_W-1:0] t);
        logic [CHAR_W-1:0] c;
        unique case (t)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: design/integer_to_roman_numeral_unit.sv
// Integer to Roman numeral unit. Each input transaction carries a 12-bit value;
// the unit answers with its Roman numeral as a run of ASCII characters, one per
// output transaction, most significant first, with o_last set on the final one.
// Zero gives a single transaction with o_empty_res set and no character, and
// values above 3999 give a single transaction with o_range_error set. A value is
// taken only when the previous run has been fully handed to the output register.
// Conversion walks the thirteen greedy terms (1000 down to 1) one step per
// cycle unless the output stalls: each cycle either emits one symbol or moves
// on to the next term, and a symbol that fits waits while the output register
// is full and not being drained.
module integer_to_roman_numeral_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rn_pkg::VALUE_W-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rn_pkg::CHAR_W-1:0]   o_symbol_char,
    output logic                        o_last,
    output logic                        o_empty_res,
    output logic                        o_range_error
);

    rn_pkg::t_cmd  cmd;
    rn_pkg::t_stat stat;

    // Sequencing and handshakes.
    rn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Remainder, term walk and output register.
    rn_datapath u_datapath (
        .i_clk         (i_clk),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_symbol_char (o_symbol_char),
        .o_last        (o_last),
        .o_empty_res   (o_empty_res),
        .o_range_error (o_range_error)
    );

`ifndef SYNTHESIS
    // An out-of-range value is answered at once with a flagged, final result.
    a_over_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_value > rn_pkg::MAX_VALUE))
        |=> (o_valid && o_range_error && o_last && !o_empty_res))
        else $error("out-of-range value not answered with a range error");

    // Flagged results carry no character and close their run.
    a_flag_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_empty_res || o_range_error))
        |-> ((o_symbol_char == rn_pkg::CH_NONE) && o_last))
        else $error("flagged result carries a character or is not last");
`endif

endmodule

FILE: design/rn_datapath.sv
module rn_datapath (
    input  logic                         i_clk,
    input  logic [rn_pkg::VALUE_W-1:0]   i_value,
    input  rn_pkg::t_cmd                 i_cmd,
    output rn_pkg::t_stat                o_stat,
    output logic [rn_pkg::CHAR_W-1:0]    o_symbol_char,
    output logic                         o_last,
    output logic                         o_empty_res,
    output logic                         o_range_error
);

    logic [rn_pkg::VALUE_W-1:0] r_rest, n_rest;
    logic [rn_pkg::TERM_W-1:0]  r_term, n_term;
    logic                       r_half, n_half;

    logic [rn_pkg::CHAR_W-1:0]  r_char, n_char;
    logic                       r_last, n_last;
    logic                       r_empty, n_empty;
    logic                       r_err, n_err;

    logic [rn_pkg::VALUE_W-1:0] weight;
    logic [rn_pkg::VALUE_W-1:0] rest_after;
    logic [rn_pkg::CHAR_W-1:0]  second;
    logic [rn_pkg::CHAR_W-1:0]  cur_char;
    logic                       term_done;

    // Current term, the symbol on offer and whether it completes the term.
    always_comb begin
        weight     = rn_pkg::term_weight(r_term);
        second     = rn_pkg::term_second(r_term);
        rest_after = r_rest - weight;
        cur_char   = r_half ? second : rn_pkg::term_first(r_term);
        term_done  = r_half || (second == rn_pkg::CH_NONE);
    end

    // Status for the controller.
    always_comb begin
        o_stat.zero = (i_value == '0);
        o_stat.over = (i_value > rn_pkg::MAX_VALUE);
        o_stat.hit  = (r_rest >= weight);
        o_stat.last = term_done && (rest_after == '0);
    end

    // Remainder, term index and pair half.
    always_comb begin
        n_rest = r_rest;
        n_term = r_term;
        n_half = r_half;
        if (i_cmd.load) begin
            n_rest = i_value;
            n_term = '0;
            n_half = 1'b0;
        end else if (i_cmd.emit) begin
            if (term_done) begin
                n_rest = rest_after;
                n_half = 1'b0;
            end else begin
                n_half = 1'b1;
            end
        end else if (i_cmd.skip) begin
            n_term = r_term + 1'b1;
        end
    end

    // Output register contents.
    always_comb begin
        n_char  = r_char;
        n_last  = r_last;
        n_empty = r_empty;
        n_err   = r_err;
        if (i_cmd.special) begin
            n_char  = rn_pkg::CH_NONE;
            n_last  = 1'b1;
            n_empty = o_stat.zero;
            n_err   = o_stat.over;
        end else if (i_cmd.emit) begin
            n_char  = cur_char;
            n_last  = o_stat.last;
            n_empty = 1'b0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_term  <= n_term;
        r_half  <= n_half;
        r_char  <= n_char;
        r_last  <= n_last;
        r_empty <= n_empty;
        r_err   <= n_err;
    end

    assign o_symbol_char = r_char;
    assign o_last        = r_last;
    assign o_empty_res   = r_empty;
    assign o_range_error = r_err;

`ifndef SYNTHESIS
    // The walk never runs past the final term.
    a_term_in_table: assert property (@(posedge i_clk)
        (i_cmd.emit || i_cmd.skip) |-> (r_term < rn_pkg::TERM_W'(rn_pkg::NTERMS)))
        else $error("term index ran past the table");

    // A second half is only ever taken for a subtractive pair.
    a_half_is_pair: assert property (@(posedge i_clk)
        (i_cmd.emit && r_half) |-> (second != rn_pkg::CH_NONE))
        else $error("second symbol taken for a single-symbol term");
`endif

endmodule

FILE: design/rn_ctrl.sv
module rn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  rn_pkg::t_stat i_stat,
    output rn_pkg::t_cmd  o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_free;
    logic   accept;

    // The output register can take a symbol when empty or being drained.
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_ovalid;

    // Commands to the datapath.
    always_comb begin
        o_cmd.special = accept && (i_stat.zero || i_stat.over);
        o_cmd.load    = accept && !(i_stat.zero || i_stat.over);
        o_cmd.emit    = (r_state == S_RUN) && out_free && i_stat.hit;
        o_cmd.skip    = (r_state == S_RUN) && !i_stat.hit;
    end

    // Next state and output valid.
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_ready;
        if (o_cmd.special || o_cmd.emit) begin
            n_ovalid = 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.emit && i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTHESIS
    // A symbol is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |-> !(o_cmd.special || o_cmd.emit))
        else $error("output register overwritten while stalled");
`endif

endmodule
